// ----- rtl/core/cpu65ex_pkg.sv -----
// Shared types and constants for the 6502 register-op execute block.
// Opcode bytes, micro-op codes, flag bit positions and the queue entry type.
// No dependencies.
`default_nettype none

package cpu65ex_pkg;

    // 6502 opcode bytes handled by the block
    localparam logic [7:0] OPC_ADC_IMM = 8'h69;
    localparam logic [7:0] OPC_SBC_IMM = 8'hE9;
    localparam logic [7:0] OPC_AND_IMM = 8'h29;
    localparam logic [7:0] OPC_EOR_IMM = 8'h49;
    localparam logic [7:0] OPC_ORA_IMM = 8'h09;
    localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
    localparam logic [7:0] OPC_CPX_IMM = 8'hE0;
    localparam logic [7:0] OPC_CPY_IMM = 8'hC0;
    localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
    localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
    localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
    localparam logic [7:0] OPC_ASL_ACC = 8'h0A;
    localparam logic [7:0] OPC_LSR_ACC = 8'h4A;
    localparam logic [7:0] OPC_ROL_ACC = 8'h2A;
    localparam logic [7:0] OPC_ROR_ACC = 8'h6A;
    localparam logic [7:0] OPC_CLC     = 8'h18;
    localparam logic [7:0] OPC_SEC     = 8'h38;
    localparam logic [7:0] OPC_CLI     = 8'h58;
    localparam logic [7:0] OPC_SEI     = 8'h78;
    localparam logic [7:0] OPC_DEX     = 8'hCA;
    localparam logic [7:0] OPC_DEY     = 8'h88;
    localparam logic [7:0] OPC_INX     = 8'hE8;
    localparam logic [7:0] OPC_INY     = 8'hC8;
    localparam logic [7:0] OPC_NOP     = 8'hEA;
    localparam logic [7:0] OPC_TAX     = 8'hAA;
    localparam logic [7:0] OPC_TAY     = 8'hA8;
    localparam logic [7:0] OPC_TSX     = 8'hBA;
    localparam logic [7:0] OPC_TXA     = 8'h8A;
    localparam logic [7:0] OPC_TXS     = 8'h9A;
    localparam logic [7:0] OPC_TYA     = 8'h98;

    // Status register bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Micro-op classes; SBC folds into ADD with a complemented operand
    typedef enum logic [4:0] {
        UOP_ADD,
        UOP_AND,
        UOP_EOR,
        UOP_ORA,
        UOP_CMP,
        UOP_CPX,
        UOP_CPY,
        UOP_LDA,
        UOP_LDX,
        UOP_LDY,
        UOP_ASL,
        UOP_LSR,
        UOP_ROL,
        UOP_ROR,
        UOP_CLC,
        UOP_SEC,
        UOP_CLI,
        UOP_SEI,
        UOP_DEX,
        UOP_DEY,
        UOP_INX,
        UOP_INY,
        UOP_NOP,
        UOP_TAX,
        UOP_TAY,
        UOP_TSX,
        UOP_TXA,
        UOP_TXS,
        UOP_TYA,
        UOP_BAD
    } t_uop_code;

    typedef struct packed {
        t_uop_code  code;
        logic [7:0] operand;
        logic       imm;      // two-byte instruction
    } t_uop;

endpackage

`default_nettype wire

// ----- rtl/core/cpu65ex_decode.sv -----
// Front end: classifies an opcode byte into a micro-op for the back end.
// Depends on cpu65ex_pkg.
`default_nettype none

module cpu65ex_decode
    import cpu65ex_pkg::*;
(
    input  wire logic [7:0] i_mode,
    input  wire logic [7:0] i_operand,
    output t_uop            o_uop
);

    always_comb begin
        o_uop.operand = i_operand;
        o_uop.imm     = 1'b0;
        o_uop.code    = UOP_BAD;
        case (i_mode)
            OPC_ADC_IMM: begin o_uop.code = UOP_ADD; o_uop.imm = 1'b1; end
            OPC_SBC_IMM: begin
                // subtract is add of the one's complement
                o_uop.code    = UOP_ADD;
                o_uop.operand = ~i_operand;
                o_uop.imm     = 1'b1;
            end
            OPC_AND_IMM: begin o_uop.code = UOP_AND; o_uop.imm = 1'b1; end
            OPC_EOR_IMM: begin o_uop.code = UOP_EOR; o_uop.imm = 1'b1; end
            OPC_ORA_IMM: begin o_uop.code = UOP_ORA; o_uop.imm = 1'b1; end
            OPC_CMP_IMM: begin o_uop.code = UOP_CMP; o_uop.imm = 1'b1; end
            OPC_CPX_IMM: begin o_uop.code = UOP_CPX; o_uop.imm = 1'b1; end
            OPC_CPY_IMM: begin o_uop.code = UOP_CPY; o_uop.imm = 1'b1; end
            OPC_LDA_IMM: begin o_uop.code = UOP_LDA; o_uop.imm = 1'b1; end
            OPC_LDX_IMM: begin o_uop.code = UOP_LDX; o_uop.imm = 1'b1; end
            OPC_LDY_IMM: begin o_uop.code = UOP_LDY; o_uop.imm = 1'b1; end
            OPC_ASL_ACC: o_uop.code = UOP_ASL;
            OPC_LSR_ACC: o_uop.code = UOP_LSR;
            OPC_ROL_ACC: o_uop.code = UOP_ROL;
            OPC_ROR_ACC: o_uop.code = UOP_ROR;
            OPC_CLC:     o_uop.code = UOP_CLC;
            OPC_SEC:     o_uop.code = UOP_SEC;
            OPC_CLI:     o_uop.code = UOP_CLI;
            OPC_SEI:     o_uop.code = UOP_SEI;
            OPC_DEX:     o_uop.code = UOP_DEX;
            OPC_DEY:     o_uop.code = UOP_DEY;
            OPC_INX:     o_uop.code = UOP_INX;
            OPC_INY:     o_uop.code = UOP_INY;
            OPC_NOP:     o_uop.code = UOP_NOP;
            OPC_TAX:     o_uop.code = UOP_TAX;
            OPC_TAY:     o_uop.code = UOP_TAY;
            OPC_TSX:     o_uop.code = UOP_TSX;
            OPC_TXA:     o_uop.code = UOP_TXA;
            OPC_TXS:     o_uop.code = UOP_TXS;
            OPC_TYA:     o_uop.code = UOP_TYA;
            default:     o_uop.code = UOP_BAD;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpu65ex_queue.sv -----
// Small FIFO of decoded micro-ops between the front and back ends.
// Depends on cpu65ex_pkg.
`default_nettype none

module cpu65ex_queue
    import cpu65ex_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_uop i_uop,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_uop      o_uop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_uop          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_uop   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_uop;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpu65ex_exec.sv -----
// Back end: holds the architectural registers and executes one micro-op per pop.
// The architectural registers double as the result register. Depends on cpu65ex_pkg.
`default_nettype none

module cpu65ex_exec
    import cpu65ex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_uop        i_uop,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_acc,
    output logic [7:0]       o_xreg,
    output logic [7:0]       o_yreg,
    output logic [7:0]       o_flags,
    output logic [7:0]       o_stack_ptr,
    output logic [15:0]      o_prog_counter,
    output logic [31:0]      o_cycle_count,
    output logic             o_illegal
);

    logic [7:0]  r_a, n_a;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [7:0]  r_p, n_p;
    logic [7:0]  r_sp, n_sp;
    logic [15:0] r_pc, n_pc;
    logic [31:0] r_cyc, n_cyc;
    logic        r_bad, n_bad;
    logic        r_valid, n_valid;

    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [7:0]  cmp_reg;
    logic [7:0]  nz_val;
    logic        nz_upd;
    logic        bad;

    // take the next micro-op when the result slot is empty or being drained
    assign o_pop = i_q_valid && (!r_valid || i_ready);

    assign sum  = {1'b0, r_a} + {1'b0, i_uop.operand} + {8'b0, r_p[FLAG_C]};
    assign diff = {1'b0, cmp_reg} - {1'b0, i_uop.operand};
    assign bad  = (i_uop.code == UOP_BAD);

    always_comb begin
        case (i_uop.code)
            UOP_CPX: cmp_reg = r_x;
            UOP_CPY: cmp_reg = r_y;
            default: cmp_reg = r_a;
        endcase
    end

    always_comb begin
        n_a    = r_a;
        n_x    = r_x;
        n_y    = r_y;
        n_p    = r_p;
        n_sp   = r_sp;
        nz_val = 8'h00;
        nz_upd = 1'b1;
        case (i_uop.code)
            UOP_ADD: begin
                n_a           = sum[7:0];
                n_p[FLAG_C]   = sum[8];
                n_p[FLAG_V]   = (r_a[7] ^ sum[7]) & (i_uop.operand[7] ^ sum[7]);
                nz_val        = sum[7:0];
            end
            UOP_AND: begin n_a = r_a & i_uop.operand; nz_val = n_a; end
            UOP_EOR: begin n_a = r_a ^ i_uop.operand; nz_val = n_a; end
            UOP_ORA: begin n_a = r_a | i_uop.operand; nz_val = n_a; end
            UOP_CMP, UOP_CPX, UOP_CPY: begin
                n_p[FLAG_C] = !diff[8];
                nz_val      = diff[7:0];
            end
            UOP_LDA: begin n_a = i_uop.operand; nz_val = n_a; end
            UOP_LDX: begin n_x = i_uop.operand; nz_val = n_x; end
            UOP_LDY: begin n_y = i_uop.operand; nz_val = n_y; end
            UOP_ASL: begin
                n_p[FLAG_C] = r_a[7];
                n_a         = {r_a[6:0], 1'b0};
                nz_val      = n_a;
            end
            UOP_LSR: begin
                n_p[FLAG_C] = r_a[0];
                n_a         = {1'b0, r_a[7:1]};
                nz_val      = n_a;
            end
            UOP_ROL: begin
                n_p[FLAG_C] = r_a[7];
                n_a         = {r_a[6:0], r_p[FLAG_C]};
                nz_val      = n_a;
            end
            UOP_ROR: begin
                n_p[FLAG_C] = r_a[0];
                n_a         = {r_p[FLAG_C], r_a[7:1]};
                nz_val      = n_a;
            end
            UOP_CLC: begin n_p[FLAG_C] = 1'b0; nz_upd = 1'b0; end
            UOP_SEC: begin n_p[FLAG_C] = 1'b1; nz_upd = 1'b0; end
            UOP_CLI: begin n_p[FLAG_I] = 1'b0; nz_upd = 1'b0; end
            UOP_SEI: begin n_p[FLAG_I] = 1'b1; nz_upd = 1'b0; end
            UOP_DEX: begin n_x = r_x - 8'd1; nz_val = n_x; end
            UOP_DEY: begin n_y = r_y - 8'd1; nz_val = n_y; end
            UOP_INX: begin n_x = r_x + 8'd1; nz_val = n_x; end
            UOP_INY: begin n_y = r_y + 8'd1; nz_val = n_y; end
            UOP_TAX: begin n_x = r_a; nz_val = n_x; end
            UOP_TAY: begin n_y = r_a; nz_val = n_y; end
            UOP_TSX: begin n_x = r_sp; nz_val = n_x; end
            UOP_TXA: begin n_a = r_x; nz_val = n_a; end
            UOP_TXS: begin n_sp = r_x; nz_upd = 1'b0; end
            UOP_TYA: begin n_a = r_y; nz_val = n_a; end
            default: nz_upd = 1'b0;    // NOP and illegal codes
        endcase
        if (nz_upd) begin
            n_p[FLAG_Z] = (nz_val == 8'h00);
            n_p[FLAG_N] = nz_val[7];
        end
    end

    always_comb begin
        n_pc    = r_pc;
        n_cyc   = r_cyc;
        n_bad   = bad;
        n_valid = r_valid && !i_ready;
        if (!bad) begin
            n_pc  = r_pc + (i_uop.imm ? 16'd2 : 16'd1);
            n_cyc = r_cyc + 32'd2;
        end
        if (o_pop) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_p     <= '0;
            r_sp    <= '0;
            r_pc    <= '0;
            r_cyc   <= '0;
            r_bad   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                r_a   <= n_a;
                r_x   <= n_x;
                r_y   <= n_y;
                r_p   <= n_p;
                r_sp  <= n_sp;
                r_pc  <= n_pc;
                r_cyc <= n_cyc;
                r_bad <= n_bad;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_acc          = r_a;
    assign o_xreg         = r_x;
    assign o_yreg         = r_y;
    assign o_flags        = r_p;
    assign o_stack_ptr    = r_sp;
    assign o_prog_counter = r_pc;
    assign o_cycle_count  = r_cyc;
    assign o_illegal      = r_bad;

endmodule

`default_nettype wire

// ----- rtl/core/cpu6502_register_op_execute.sv -----
// Top level of the 6502 register-op execute block: decode, micro-op queue, execute.
// Depends on cpu65ex_pkg, cpu65ex_decode, cpu65ex_queue and cpu65ex_exec.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------------
//   request   i_valid / o_ready    i_mode, i_operand
//   result    o_valid / i_ready    o_acc .. o_cycle_count, o_illegal
//
// One request per clock sustained while the result channel keeps taking results;
// an accepted request is written into the queue, then popped into the execute
// registers, which raise o_valid; a stalled result channel holds it in the queue.
// The front end stalls only when the queue is full; the execute stage drains
// the queue whenever its result register is empty or being taken.
// Synchronous active-low reset clears all registers, the queue and the result slot.
`default_nettype none

module cpu6502_register_op_execute
    import cpu65ex_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_mode,
    input  wire logic [7:0]  i_operand,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_acc,
    output logic [7:0]       o_xreg,
    output logic [7:0]       o_yreg,
    output logic [7:0]       o_flags,
    output logic [7:0]       o_stack_ptr,
    output logic [15:0]      o_prog_counter,
    output logic [31:0]      o_cycle_count,
    output logic             o_illegal
);

    t_uop dec_uop;
    t_uop q_uop;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;

    assign o_ready = !q_full;
    assign push    = i_valid && o_ready;

    cpu65ex_decode u_decode (
        .i_mode    (i_mode),
        .i_operand (i_operand),
        .o_uop     (dec_uop)
    );

    cpu65ex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (dec_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_uop   (q_uop)
    );

    cpu65ex_exec u_exec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_uop          (q_uop),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_acc          (o_acc),
        .o_xreg         (o_xreg),
        .o_yreg         (o_yreg),
        .o_flags        (o_flags),
        .o_stack_ptr    (o_stack_ptr),
        .o_prog_counter (o_prog_counter),
        .o_cycle_count  (o_cycle_count),
        .o_illegal      (o_illegal)
    );

    // cycle count only ever moves in steps of two
    a_cycle_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cycle_count[0] == 1'b0)
        else $error("cycle count became odd");

    // a change of the cycle count comes with a fresh, legal result
    a_cycle_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_cycle_count != $past(o_cycle_count))
        |-> o_valid && !o_illegal)
        else $error("cycle count moved without a legal instruction");

    // program counter only advances together with the cycle count
    a_pc_with_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_prog_counter != $past(o_prog_counter))
        |-> o_cycle_count != $past(o_cycle_count))
        else $error("program counter moved without a cycle count step");

    // the front end never backs up while the queue has room
    a_ready_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> q_valid && !push)
        else $error("front end stalled with queue room");

endmodule

`default_nettype wire

// ----- tb/sv/cpu6502_register_op_execute_test.sv -----
// Self-checking bench for cpu6502_register_op_execute: directed table, then random opcodes.
// Needs cpu65ex_pkg and the block; a built-in predictor supplies each untyped row's expected register set.
`timescale 1ns / 100ps

module cpu6502_register_op_execute_test
    import cpu65ex_pkg::*;
();

    // Opcodes outside the supported subset
    localparam logic [7:0] OPC_UNSUPPORTED_LO = 8'h00;
    localparam logic [7:0] OPC_UNSUPPORTED_HI = 8'hFF;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_SLICE = 317;

    localparam logic [7:0] SUPPORTED_OPCODES [30] = '{
        OPC_ADC_IMM, OPC_SBC_IMM, OPC_AND_IMM, OPC_EOR_IMM, OPC_ORA_IMM, OPC_CMP_IMM,
        OPC_CPX_IMM, OPC_CPY_IMM, OPC_LDA_IMM, OPC_LDX_IMM, OPC_LDY_IMM, OPC_ASL_ACC,
        OPC_LSR_ACC, OPC_ROL_ACC, OPC_ROR_ACC, OPC_CLC, OPC_SEC, OPC_CLI, OPC_SEI,
        OPC_DEX, OPC_DEY, OPC_INX, OPC_INY, OPC_NOP, OPC_TAX, OPC_TAY, OPC_TSX,
        OPC_TXA, OPC_TXS, OPC_TYA
    };

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  xreg;
        logic [7:0]  yreg;
        logic [7:0]  flags;
        logic [7:0]  sp;
        logic [15:0] pc;
        logic [31:0] cyc;
        logic        illegal;
    } t_cpu_regs;

    typedef struct packed {
        logic [7:0] opc;
        logic [7:0] imm;
        logic       typed;
        t_cpu_regs  want;
    } t_opcode_row;

    // Only the first rows carry typed-in register sets; the rest use the predictor
    t_opcode_row opcode_table [33] = '{
        '{OPC_UNSUPPORTED_LO, 8'hFF, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b1}},
        '{OPC_LDA_IMM, 8'h00, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 16'h0002, 32'h2, 1'b0}},
        '{OPC_LDA_IMM, 8'hFF, 1'b1,
          '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h00, 16'h0004, 32'h4, 1'b0}},
        '{OPC_UNSUPPORTED_HI, 8'h00, 1'b1,
          '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h00, 16'h0004, 32'h4, 1'b1}},
        '{OPC_ADC_IMM, 8'h01, 1'b0, '0},
        '{OPC_ADC_IMM, 8'h7F, 1'b0, '0},
        '{OPC_SBC_IMM, 8'hFF, 1'b0, '0},
        '{OPC_AND_IMM, 8'hAA, 1'b0, '0},
        '{OPC_ORA_IMM, 8'h55, 1'b0, '0},
        '{OPC_EOR_IMM, 8'hFF, 1'b0, '0},
        '{OPC_CMP_IMM, 8'h80, 1'b0, '0},
        '{OPC_CPX_IMM, 8'h00, 1'b0, '0},
        '{OPC_CPY_IMM, 8'hFF, 1'b0, '0},
        '{OPC_LDX_IMM, 8'hFF, 1'b0, '0},
        '{OPC_LDY_IMM, 8'h80, 1'b0, '0},
        '{OPC_ASL_ACC, 8'hFF, 1'b0, '0},
        '{OPC_ROL_ACC, 8'h00, 1'b0, '0},
        '{OPC_LSR_ACC, 8'hFF, 1'b0, '0},
        '{OPC_ROR_ACC, 8'h00, 1'b0, '0},
        '{OPC_SEC, 8'h00, 1'b0, '0},
        '{OPC_CLC, 8'hFF, 1'b0, '0},
        '{OPC_SEI, 8'h00, 1'b0, '0},
        '{OPC_CLI, 8'hFF, 1'b0, '0},
        '{OPC_INX, 8'h00, 1'b0, '0},
        '{OPC_DEX, 8'h00, 1'b0, '0},
        '{OPC_DEY, 8'h00, 1'b0, '0},
        '{OPC_INY, 8'h00, 1'b0, '0},
        '{OPC_TXS, 8'h00, 1'b0, '0},
        '{OPC_TAX, 8'h00, 1'b0, '0},
        '{OPC_TSX, 8'h00, 1'b0, '0},
        '{OPC_TAY, 8'h00, 1'b0, '0},
        '{OPC_TXA, 8'h00, 1'b0, '0},
        '{OPC_TYA, 8'hFF, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_mode = 8'h00;
    logic [7:0]  i_operand = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_acc;
    logic [7:0]  o_xreg;
    logic [7:0]  o_yreg;
    logic [7:0]  o_flags;
    logic [7:0]  o_stack_ptr;
    logic [15:0] o_prog_counter;
    logic [31:0] o_cycle_count;
    logic        o_illegal;

    t_cpu_regs arch_state = '0;
    t_cpu_regs pending_regs [$];
    t_cpu_regs want_regs;
    int        mismatch_count = 0;
    int        cycle_total = 0;
    int        send_idle_pct = 6;
    int        recv_idle_pct = 83;
    int        hold_seq = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    cpu6502_register_op_execute uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_operand      (i_operand),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_acc          (o_acc),
        .o_xreg         (o_xreg),
        .o_yreg         (o_yreg),
        .o_flags        (o_flags),
        .o_stack_ptr    (o_stack_ptr),
        .o_prog_counter (o_prog_counter),
        .o_cycle_count  (o_cycle_count),
        .o_illegal      (o_illegal)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] with_nz(logic [7:0] f, logic [7:0] v);
        f[FLAG_Z] = (v == 8'h00);
        f[FLAG_N] = v[7];
        return f;
    endfunction

    // Register set after one instruction; also the next architectural state
    function automatic t_cpu_regs execute_opcode(t_cpu_regs s, logic [7:0] opc,
                                                 logic [7:0] imm);
        logic [8:0] sum;
        logic [7:0] addend;
        logic [7:0] cmp_reg;
        logic [7:0] diff;
        logic       carry;
        logic       two_byte;
        s.illegal = 1'b0;
        two_byte = 1'b0;
        carry = s.flags[FLAG_C];
        case (opc)
            OPC_ADC_IMM, OPC_SBC_IMM: begin
                addend = (opc == OPC_SBC_IMM) ? ~imm : imm;
                sum = {1'b0, s.acc} + {1'b0, addend} + {8'h00, carry};
                s.flags[FLAG_C] = sum[8];
                s.flags[FLAG_V] = (s.acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
                s.acc = sum[7:0];
                s.flags = with_nz(s.flags, s.acc);
                two_byte = 1'b1;
            end
            OPC_AND_IMM: begin
                s.acc = s.acc & imm;
                s.flags = with_nz(s.flags, s.acc);
                two_byte = 1'b1;
            end
            OPC_EOR_IMM: begin
                s.acc = s.acc ^ imm;
                s.flags = with_nz(s.flags, s.acc);
                two_byte = 1'b1;
            end
            OPC_ORA_IMM: begin
                s.acc = s.acc | imm;
                s.flags = with_nz(s.flags, s.acc);
                two_byte = 1'b1;
            end
            OPC_CMP_IMM, OPC_CPX_IMM, OPC_CPY_IMM: begin
                cmp_reg = (opc == OPC_CMP_IMM) ? s.acc :
                          (opc == OPC_CPX_IMM) ? s.xreg : s.yreg;
                diff = cmp_reg - imm;
                s.flags[FLAG_C] = (cmp_reg >= imm);
                s.flags = with_nz(s.flags, diff);
                two_byte = 1'b1;
            end
            OPC_LDA_IMM: begin
                s.acc = imm;
                s.flags = with_nz(s.flags, imm);
                two_byte = 1'b1;
            end
            OPC_LDX_IMM: begin
                s.xreg = imm;
                s.flags = with_nz(s.flags, imm);
                two_byte = 1'b1;
            end
            OPC_LDY_IMM: begin
                s.yreg = imm;
                s.flags = with_nz(s.flags, imm);
                two_byte = 1'b1;
            end
            OPC_ASL_ACC: begin
                s.flags[FLAG_C] = s.acc[7];
                s.acc = {s.acc[6:0], 1'b0};
                s.flags = with_nz(s.flags, s.acc);
            end
            OPC_LSR_ACC: begin
                s.flags[FLAG_C] = s.acc[0];
                s.acc = {1'b0, s.acc[7:1]};
                s.flags = with_nz(s.flags, s.acc);
            end
            OPC_ROL_ACC: begin
                s.flags[FLAG_C] = s.acc[7];
                s.acc = {s.acc[6:0], carry};
                s.flags = with_nz(s.flags, s.acc);
            end
            OPC_ROR_ACC: begin
                s.flags[FLAG_C] = s.acc[0];
                s.acc = {carry, s.acc[7:1]};
                s.flags = with_nz(s.flags, s.acc);
            end
            OPC_CLC: s.flags[FLAG_C] = 1'b0;
            OPC_SEC: s.flags[FLAG_C] = 1'b1;
            OPC_CLI: s.flags[FLAG_I] = 1'b0;
            OPC_SEI: s.flags[FLAG_I] = 1'b1;
            OPC_DEX: begin
                s.xreg = s.xreg - 8'd1;
                s.flags = with_nz(s.flags, s.xreg);
            end
            OPC_DEY: begin
                s.yreg = s.yreg - 8'd1;
                s.flags = with_nz(s.flags, s.yreg);
            end
            OPC_INX: begin
                s.xreg = s.xreg + 8'd1;
                s.flags = with_nz(s.flags, s.xreg);
            end
            OPC_INY: begin
                s.yreg = s.yreg + 8'd1;
                s.flags = with_nz(s.flags, s.yreg);
            end
            OPC_NOP: ;
            OPC_TAX: begin
                s.xreg = s.acc;
                s.flags = with_nz(s.flags, s.xreg);
            end
            OPC_TAY: begin
                s.yreg = s.acc;
                s.flags = with_nz(s.flags, s.yreg);
            end
            OPC_TSX: begin
                s.xreg = s.sp;
                s.flags = with_nz(s.flags, s.xreg);
            end
            OPC_TXA: begin
                s.acc = s.xreg;
                s.flags = with_nz(s.flags, s.acc);
            end
            OPC_TXS: s.sp = s.xreg;
            OPC_TYA: begin
                s.acc = s.yreg;
                s.flags = with_nz(s.flags, s.acc);
            end
            default: s.illegal = 1'b1;
        endcase
        if (!s.illegal) begin
            s.pc = s.pc + (two_byte ? 16'd2 : 16'd1);
            s.cyc = s.cyc + 32'd2;
        end
        return s;
    endfunction

    // Present one request at a falling edge and hold it until the block takes it
    task automatic offer_request(input logic [7:0] opc, input logic [7:0] imm,
                                 input logic typed, input t_cpu_regs typed_regs);
        t_cpu_regs predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= opc;
        i_operand <= imm;
        do @(posedge i_clk); while (!o_ready);
        predicted = execute_opcode(arch_state, opc, imm);
        arch_state = predicted;
        pending_regs.push_back(typed ? typed_regs : predicted);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic [7:0] opc;
        logic [7:0] imm;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85)
                opc = SUPPORTED_OPCODES[5'($urandom_range(29))];
            else
                opc = 8'($urandom_range(255));
            case ($urandom_range(9))
                0: imm = 8'h00;
                1: imm = 8'hFF;
                2: imm = {1'($urandom_range(1)), 7'h7F};
                default: imm = 8'($urandom_range(255));
            endcase
            offer_request(opc, imm, 1'b0, '0);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_pending();
        i_valid <= 1'b0;
        while (pending_regs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_regs.size() == 0) begin
                $error("result with no request pending");
                mismatch_count++;
            end else begin
                want_regs = pending_regs.pop_front();
                check_field("acc", 32'(want_regs.acc), 32'(o_acc));
                check_field("xreg", 32'(want_regs.xreg), 32'(o_xreg));
                check_field("yreg", 32'(want_regs.yreg), 32'(o_yreg));
                check_field("flags", 32'(want_regs.flags), 32'(o_flags));
                check_field("stack_ptr", 32'(want_regs.sp), 32'(o_stack_ptr));
                check_field("prog_counter", 32'(want_regs.pc), 32'(o_prog_counter));
                check_field("cycle_count", want_regs.cyc, o_cycle_count);
                check_field("illegal", 32'(want_regs.illegal), 32'(o_illegal));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_total++;
        if (cycle_total > CYCLE_LIMIT) begin
            $display("cpu6502_register_op_execute_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Slow receiver, busy sender
        foreach (opcode_table[k])
            offer_request(opcode_table[k].opc, opcode_table[k].imm,
                          opcode_table[k].typed, opcode_table[k].want);
        run_random(RANDOM_SLICE);
        drain_pending();

        // Slow sender, busy receiver
        send_idle_pct = 83;
        recv_idle_pct = 6;
        run_random(RANDOM_SLICE);
        drain_pending();

        // Full rate, opening with a long receiver hold so the queue backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq++;
        run_random(RANDOM_SLICE);
        drain_pending();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("cpu6502_register_op_execute_test: done, clean");
        else
            $display("cpu6502_register_op_execute_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cpu65ex_pkg.sv
rtl/core/cpu65ex_decode.sv
rtl/core/cpu65ex_queue.sv
rtl/core/cpu65ex_exec.sv
rtl/core/cpu6502_register_op_execute.sv
tb/sv/cpu6502_register_op_execute_test.sv
